// File: sv/bsm_pkg.sv
// shared constants, types and the reciprocal table of the 3x3 box smoother
// no dependencies; every file but bsm_line_ram uses it through scoped names
package bsm_pkg;

  localparam int MAX_SIZE   = 1024;
  localparam int RESET_SIZE = 1024;
  localparam int POS_W      = $clog2(MAX_SIZE);
  localparam int OUT_POS_W  = 10;
  localparam int SIZE_W     = 11;
  localparam int CH_W       = 16;
  localparam int PIX_W      = 3 * CH_W;
  localparam int LINE_W     = 2 * PIX_W;
  localparam int SUM_W      = 20;
  localparam int CNT_W      = 4;
  localparam int K_W        = 20;
  localparam int SH_W       = 5;
  localparam int PROD_W     = SUM_W + K_W;

  localparam logic [POS_W-1:0] SIZE_RST_M1 =
    POS_W'((RESET_SIZE > MAX_SIZE ? MAX_SIZE : RESET_SIZE) - 1);

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic [OUT_POS_W-1:0] row;
    logic [OUT_POS_W-1:0] col;
    logic                 run_last;
    logic                 frame_end;
  } res_tag_t;

  typedef struct packed {
    res_tag_t         tag;
    logic [CNT_W-1:0] cnt;
    sum_t             sum_red;
    sum_t             sum_green;
    sum_t             sum_blue;
  } mean_req_t;

  typedef struct packed {
    logic [K_W-1:0]  k;
    logic [SH_W-1:0] sh;
  } recip_t;

  // floor(x / cnt) == (x * k) >> sh for cnt in 1, 2, 3, 4, 6, 9 and every x below 2**SUM_W
  function automatic recip_t recip(input logic [CNT_W-1:0] cnt);
    recip_t r;
    unique case (cnt)
      4'd1:    r = '{k: K_W'(1),      sh: SH_W'(0)};
      4'd2:    r = '{k: K_W'(1),      sh: SH_W'(1)};
      4'd3:    r = '{k: K_W'(699051), sh: SH_W'(21)};
      4'd4:    r = '{k: K_W'(1),      sh: SH_W'(2)};
      4'd6:    r = '{k: K_W'(699051), sh: SH_W'(22)};
      4'd9:    r = '{k: K_W'(932068), sh: SH_W'(23)};
      default: r = '{k: K_W'(1),      sh: SH_W'(0)};
    endcase
    return r;
  endfunction

endpackage

// File: sv/bsm_if.sv
// valid/ready channels of the box smoother: pixel in, result out, config write
// depends on bsm_pkg for field widths
interface bsm_pix_if;
  logic                     valid;
  logic                     ready;
  logic [bsm_pkg::CH_W-1:0] red_in;
  logic [bsm_pkg::CH_W-1:0] green_in;
  logic [bsm_pkg::CH_W-1:0] blue_in;
  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface bsm_res_if;
  logic                          valid;
  logic                          ready;
  logic [bsm_pkg::OUT_POS_W-1:0] out_row;
  logic [bsm_pkg::OUT_POS_W-1:0] out_col;
  logic [bsm_pkg::CH_W-1:0]      out_red;
  logic [bsm_pkg::CH_W-1:0]      out_green;
  logic [bsm_pkg::CH_W-1:0]      out_blue;
  logic                          run_last;
  logic                          frame_end;
  modport source (output valid, out_row, out_col, out_red, out_green, out_blue,
                  run_last, frame_end, input ready);
  modport sink   (input valid, out_row, out_col, out_red, out_green, out_blue,
                  run_last, frame_end, output ready);
endinterface

interface bsm_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [bsm_pkg::SIZE_W-1:0] image_size;
  modport source (output valid, image_size, input ready);
  modport sink   (input valid, image_size, output ready);
endinterface

// File: sv/bsm_line_ram.sv
// generic single-port-write, single-port-read synchronous ram, registered read
// standalone; no package dependency
module bsm_line_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/bsm_mean.sv
// mean pipeline: registered sums, reciprocal multiply, shift into output register
// depends on bsm_pkg and bsm_res_if
module bsm_mean (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_valid,
  output logic               req_ready,
  input  bsm_pkg::mean_req_t req,
  bsm_res_if.source          res
);

  logic                       v_a_r;
  bsm_pkg::mean_req_t         req_a_r;
  logic                       v_b_r;
  logic [bsm_pkg::PROD_W-1:0] prod_red_r, prod_green_r, prod_blue_r;
  logic [bsm_pkg::SH_W-1:0]   sh_b_r;
  bsm_pkg::res_tag_t          tag_b_r;
  logic                       out_v_r;

  logic                       o_rdy, b_rdy, a_rdy;
  bsm_pkg::recip_t            rc;
  logic [bsm_pkg::PROD_W-1:0] prod_red_nxt, prod_green_nxt, prod_blue_nxt;

  assign o_rdy     = !out_v_r || res.ready;
  assign b_rdy     = !v_b_r || o_rdy;
  assign a_rdy     = !v_a_r || b_rdy;
  assign req_ready = a_rdy;

  always_comb begin
    rc = bsm_pkg::recip(req_a_r.cnt);
    prod_red_nxt   = bsm_pkg::PROD_W'(req_a_r.sum_red)   * bsm_pkg::PROD_W'(rc.k);
    prod_green_nxt = bsm_pkg::PROD_W'(req_a_r.sum_green) * bsm_pkg::PROD_W'(rc.k);
    prod_blue_nxt  = bsm_pkg::PROD_W'(req_a_r.sum_blue)  * bsm_pkg::PROD_W'(rc.k);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r   <= 1'b0;
      v_b_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (a_rdy) begin
        v_a_r <= req_valid;
      end
      if (b_rdy) begin
        v_b_r <= v_a_r;
      end
      if (o_rdy) begin
        out_v_r <= v_b_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && req_valid) begin
      req_a_r <= req;
    end
    if (b_rdy && v_a_r) begin
      prod_red_r   <= prod_red_nxt;
      prod_green_r <= prod_green_nxt;
      prod_blue_r  <= prod_blue_nxt;
      sh_b_r       <= rc.sh;
      tag_b_r      <= req_a_r.tag;
    end
    if (o_rdy && v_b_r) begin
      res.out_row   <= tag_b_r.row;
      res.out_col   <= tag_b_r.col;
      res.out_red   <= bsm_pkg::CH_W'(prod_red_r >> sh_b_r);
      res.out_green <= bsm_pkg::CH_W'(prod_green_r >> sh_b_r);
      res.out_blue  <= bsm_pkg::CH_W'(prod_blue_r >> sh_b_r);
      res.run_last  <= tag_b_r.run_last;
      res.frame_end <= tag_b_r.frame_end;
    end
  end

  assign res.valid = out_v_r;

endmodule

// File: sv/box_smooth_3x3_core.sv
// streaming 3x3 box smoother over a square rgb image, raster order in and out
// path: item stage, then the mean pipeline's request, product and output registers
// throughput: one item per cycle while the mean pipeline takes requests; an item causing
// k > 1 results holds the input until the single-issue result sequencer has issued them all
// reset: counters cleared, size back to 1024 clipped to MAX_SIZE; line ram not cleared
// depends on bsm_pkg, bsm_if, bsm_line_ram, bsm_mean
module box_smooth_3x3_core (
  input  logic      clk,
  input  logic      rst_n,
  bsm_cfg_if.sink   cfg_ch,
  bsm_pix_if.sink   in_ch,
  bsm_res_if.source out_ch
);

  // ---------------------------------------------------------------------------
  // position counters and the effective size (held as size minus one)
  // ---------------------------------------------------------------------------
  logic [bsm_pkg::POS_W-1:0] size_m1_r, size_m1_nxt;
  logic [bsm_pkg::POS_W-1:0] row_r, row_nxt;
  logic [bsm_pkg::POS_W-1:0] col_r, col_nxt;
  logic                      cfg_wr;
  logic                      accept;

  // ---------------------------------------------------------------------------
  // item stage: the pixel whose line ram read is in flight or done
  // ---------------------------------------------------------------------------
  logic                      s1_v_r;
  logic [3:0]                pend_r, pend_nxt;
  bsm_pkg::pix_t             cur_r;
  logic [bsm_pkg::POS_W-1:0] s1_row_r, s1_col_r;
  logic                      s1_rge1_r, s1_rge2_r, s1_cge1_r, s1_cge2_r;

  // forwarding of a same-address write that lands on the read edge
  logic                       fwd_r;
  logic [bsm_pkg::LINE_W-1:0] fwd_data_r;

  // column window: columns c-1 and c-2 for rows r-2, r-1, r
  bsm_pkg::pix_t win_m1_r [3];
  bsm_pkg::pix_t win_m2_r [3];

  // line ram entry: older line in the upper half, newer line in the lower
  logic [bsm_pkg::LINE_W-1:0] ram_q;
  logic [bsm_pkg::LINE_W-1:0] line_rd;
  logic [bsm_pkg::LINE_W-1:0] line_wr;
  bsm_pkg::pix_t              newcol [3];
  bsm_pkg::pix_t              pix [3][3];

  // result sequencer
  logic [1:0]                idx;
  logic [3:0]                sel_oh;
  logic [3:0]                rem;
  logic [2:0]                rowm, colm;
  logic [1:0]                nrow, ncol;
  logic                      issue;
  logic                      s1_retire;
  logic                      req_ready;
  bsm_pkg::mean_req_t        req;
  bsm_pkg::sum_t             sum_ch [3];
  logic [bsm_pkg::POS_W-1:0] res_row, res_col;

  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;

  // size zero acts as one, anything above the line depth is clipped
  always_comb begin
    if (cfg_ch.image_size == '0) begin
      size_m1_nxt = '0;
    end else if (int'(cfg_ch.image_size) > bsm_pkg::MAX_SIZE) begin
      size_m1_nxt = bsm_pkg::POS_W'(bsm_pkg::MAX_SIZE - 1);
    end else begin
      size_m1_nxt = bsm_pkg::POS_W'(int'(cfg_ch.image_size) - 1);
    end
  end

  // raster advance, wrapping at the end of the frame
  always_comb begin
    if (col_r == size_m1_r) begin
      col_nxt = '0;
      row_nxt = (row_r == size_m1_r) ? '0 : row_r + bsm_pkg::POS_W'(1);
    end else begin
      col_nxt = col_r + bsm_pkg::POS_W'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_m1_r <= bsm_pkg::SIZE_RST_M1;
      row_r     <= '0;
      col_r     <= '0;
    end else if (cfg_wr) begin
      // any size write restarts the frame
      size_m1_r <= size_m1_nxt;
      row_r     <= '0;
      col_r     <= '0;
    end else if (accept) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // line ram: read at accept, written back when the item retires
  // ---------------------------------------------------------------------------
  bsm_line_ram #(
    .WIDTH (bsm_pkg::LINE_W),
    .DEPTH (bsm_pkg::MAX_SIZE)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_retire),
    .wr_addr (s1_col_r),
    .wr_data (line_wr),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (ram_q)
  );

  // a write and a read of the same column only meet on one edge (size one)
  assign line_rd = fwd_r ? fwd_data_r : ram_q;

  // newest column of the 3x3 grid
  assign newcol[0] = line_rd[bsm_pkg::LINE_W-1:bsm_pkg::PIX_W];
  assign newcol[1] = line_rd[bsm_pkg::PIX_W-1:0];
  assign newcol[2] = cur_r;

  // line shift: newer moves to older, current pixel becomes newer
  assign line_wr = {newcol[1], cur_r};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pix[k][0] = win_m2_r[k];
      pix[k][1] = win_m1_r[k];
      pix[k][2] = newcol[k];
    end
  end

  // ---------------------------------------------------------------------------
  // result sequencer: one pending result issued per cycle while req_ready, raster order
  // pend bits: 0 (r-1,c-1), 1 (r-1,c), 2 (r,c-1), 3 (r,c)
  // ---------------------------------------------------------------------------
  always_comb begin
    priority if (pend_r[0]) begin
      idx = 2'd0;
    end else if (pend_r[1]) begin
      idx = 2'd1;
    end else if (pend_r[2]) begin
      idx = 2'd2;
    end else begin
      idx = 2'd3;
    end
    sel_oh = 4'b0001 << idx;
    rem    = pend_r & ~sel_oh;

    // rows and columns of the grid that fall inside the image
    rowm = idx[1] ? {1'b1, s1_rge1_r, 1'b0} : {1'b1, 1'b1, s1_rge2_r};
    colm = idx[0] ? {1'b1, s1_cge1_r, 1'b0} : {1'b1, 1'b1, s1_cge2_r};
    nrow = 2'(rowm[0]) + 2'(rowm[1]) + 2'(rowm[2]);
    ncol = 2'(colm[0]) + 2'(colm[1]) + 2'(colm[2]);

    for (int q = 0; q < 3; q++) begin
      sum_ch[q] = '0;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          if (rowm[k] && colm[j]) begin
            sum_ch[q] = sum_ch[q]
                      + bsm_pkg::SUM_W'(pix[k][j][q*bsm_pkg::CH_W +: bsm_pkg::CH_W]);
          end
        end
      end
    end

    res_row = idx[1] ? s1_row_r : s1_row_r - bsm_pkg::POS_W'(1);
    res_col = idx[0] ? s1_col_r : s1_col_r - bsm_pkg::POS_W'(1);

    req.tag.row       = bsm_pkg::OUT_POS_W'(res_row);
    req.tag.col       = bsm_pkg::OUT_POS_W'(res_col);
    req.tag.run_last  = (rem == '0);
    // only the bottom-right result can be the frame's final pixel
    req.tag.frame_end = (idx == 2'd3);
    req.cnt           = bsm_pkg::CNT_W'(nrow) * bsm_pkg::CNT_W'(ncol);
    req.sum_red       = sum_ch[0];
    req.sum_green     = sum_ch[1];
    req.sum_blue      = sum_ch[2];
  end

  assign issue     = s1_v_r && (pend_r != '0) && req_ready;
  // retire in the same cycle as the last result goes out
  assign s1_retire = s1_v_r && ((pend_r == '0) || (issue && (rem == '0)));
  assign in_ch.ready = !s1_v_r || s1_retire;

  // results an incoming pixel completes, from its position
  always_comb begin
    pend_nxt[0] = (row_r != '0) && (col_r != '0);
    pend_nxt[1] = (row_r != '0) && (col_r == size_m1_r);
    pend_nxt[2] = (row_r == size_m1_r) && (col_r != '0);
    pend_nxt[3] = (row_r == size_m1_r) && (col_r == size_m1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      pend_r <= '0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
      pend_r <= pend_nxt;
    end else if (s1_retire) begin
      s1_v_r <= 1'b0;
      pend_r <= '0;
    end else if (issue) begin
      pend_r <= rem;
    end
  end

  // item payload, captured with the ram read
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_r      <= {in_ch.blue_in, in_ch.green_in, in_ch.red_in};
      s1_row_r   <= row_r;
      s1_col_r   <= col_r;
      s1_rge1_r  <= (row_r != '0);
      s1_rge2_r  <= (row_r > bsm_pkg::POS_W'(1));
      s1_cge1_r  <= (col_r != '0);
      s1_cge2_r  <= (col_r > bsm_pkg::POS_W'(1));
      fwd_r      <= s1_retire && (s1_col_r == col_r);
      fwd_data_r <= line_wr;
    end
  end

  // column window shifts as each item retires
  always_ff @(posedge clk) begin
    if (s1_retire) begin
      for (int k = 0; k < 3; k++) begin
        win_m2_r[k] <= win_m1_r[k];
        win_m1_r[k] <= newcol[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // mean pipeline and output register
  // ---------------------------------------------------------------------------
  bsm_mean u_mean (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (s1_v_r && (pend_r != '0)),
    .req_ready (req_ready),
    .req       (req),
    .res       (out_ch)
  );

endmodule

// File: bench/tb_box_smooth_3x3_core.sv
`timescale 1ns / 1ps
// self-checking bench of box_smooth_3x3_core: raster pixels in, smoothed pixels out
// depends on bsm_pkg and the channel interfaces in bsm_if
module tb_box_smooth_3x3_core;

  localparam int RAND_ITEMS    = 240;     // random pixels after the directed table
  localparam int QUIET_ITEMS   = 50;      // tail of the random part with no idling
  localparam int SETTLE_CYCLES = 10;
  localparam int TAIL_CYCLES   = 20;
  localparam int LONG_HOLD     = 120;     // long receiver hold-off, in cycles
  localparam int CYCLE_LIMIT   = 200000;

  // one smoothed pixel as the result channel carries it
  typedef struct packed {
    logic [bsm_pkg::OUT_POS_W-1:0] row;
    logic [bsm_pkg::OUT_POS_W-1:0] col;
    logic [bsm_pkg::CH_W-1:0]      red;
    logic [bsm_pkg::CH_W-1:0]      green;
    logic [bsm_pkg::CH_W-1:0]      blue;
    logic                          run_last;
    logic                          frame_end;
  } smoothed_t;

  // what a row of the directed table does
  typedef enum logic [1:0] {
    ROW_SIZE,       // write image_size
    ROW_PREDICT,    // send a pixel, results come from the predictor
    ROW_NO_RESULT,  // send a pixel that must cause no result
    ROW_TYPED       // send a pixel whose single result is typed in the row
  } row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [bsm_pkg::SIZE_W-1:0] size;
    logic [bsm_pkg::CH_W-1:0]   red;
    logic [bsm_pkg::CH_W-1:0]   green;
    logic [bsm_pkg::CH_W-1:0]   blue;
    smoothed_t                  want;
  } stim_row_t;

  localparam smoothed_t NO_WANT = '0;
  localparam int DIR_ROWS = 26;

  logic clk;
  logic rst_n;

  bsm_cfg_if cfg_if ();
  bsm_pix_if pix_if ();
  bsm_res_if res_if ();

  box_smooth_3x3_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_if),
    .in_ch  (pix_if),
    .out_ch (res_if)
  );

  // ---------------------------------------------------------------------------
  // directed table: reset size, size zero and oversize, a single-pixel image,
  // then whole 2x2 and 3x3 frames with channel extremes
  // ---------------------------------------------------------------------------
  stim_row_t dir_table [DIR_ROWS] = '{
    // still at the reset size of 1024: row 0 causes nothing
    '{ROW_NO_RESULT, 11'd0, 16'h0000, 16'h0000, 16'h0000, NO_WANT},
    '{ROW_NO_RESULT, 11'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, NO_WANT},
    // size zero behaves as a 1x1 image: every pixel passes through
    '{ROW_SIZE, 11'd0, 16'h0000, 16'h0000, 16'h0000, NO_WANT},
    '{ROW_TYPED, 11'd0, 16'hFFFF, 16'h0000, 16'h1234,
      '{10'd0, 10'd0, 16'hFFFF, 16'h0000, 16'h1234, 1'b1, 1'b1}},
    '{ROW_TYPED, 11'd0, 16'h0000, 16'hFFFF, 16'hA5A5,
      '{10'd0, 10'd0, 16'h0000, 16'hFFFF, 16'hA5A5, 1'b1, 1'b1}},
    '{ROW_SIZE, 11'd1, 16'h0000, 16'h0000, 16'h0000, NO_WANT},
    '{ROW_TYPED, 11'd0, 16'h8000, 16'h7FFF, 16'h0001,
      '{10'd0, 10'd0, 16'h8000, 16'h7FFF, 16'h0001, 1'b1, 1'b1}},
    // oversize clamps to the largest image, first row again silent
    '{ROW_SIZE, 11'd2047, 16'h0000, 16'h0000, 16'h0000, NO_WANT},
    '{ROW_NO_RESULT, 11'd0, 16'h0001, 16'h0002, 16'h0003, NO_WANT},
    '{ROW_SIZE, 11'd1024, 16'h0000, 16'h0000, 16'h0000, NO_WANT},
    '{ROW_NO_RESULT, 11'd0, 16'hFFFF, 16'h0000, 16'hFFFF, NO_WANT},
    // 2x2: all four results come out on the last pixel
    '{ROW_SIZE, 11'd2, 16'h0000, 16'h0000, 16'h0000, NO_WANT},
    '{ROW_PREDICT, 11'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, NO_WANT},
    '{ROW_PREDICT, 11'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, NO_WANT},
    '{ROW_PREDICT, 11'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, NO_WANT},
    '{ROW_PREDICT, 11'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, NO_WANT},
    // 3x3: corner, edge and full neighborhoods
    '{ROW_SIZE, 11'd3, 16'h0000, 16'h0000, 16'h0000, NO_WANT},
    '{ROW_PREDICT, 11'd0, 16'hFFFF, 16'h0000, 16'hFFFF, NO_WANT},
    '{ROW_PREDICT, 11'd0, 16'h0000, 16'hFFFF, 16'h0000, NO_WANT},
    '{ROW_PREDICT, 11'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, NO_WANT},
    '{ROW_PREDICT, 11'd0, 16'h0000, 16'h0000, 16'h0000, NO_WANT},
    '{ROW_PREDICT, 11'd0, 16'hFFFF, 16'h0000, 16'h8001, NO_WANT},
    '{ROW_PREDICT, 11'd0, 16'h1234, 16'h5678, 16'h9ABC, NO_WANT},
    '{ROW_PREDICT, 11'd0, 16'hFFFF, 16'hFFFF, 16'h0000, NO_WANT},
    '{ROW_PREDICT, 11'd0, 16'h0001, 16'h0002, 16'h0003, NO_WANT},
    '{ROW_PREDICT, 11'd0, 16'hFFFE, 16'hFFFD, 16'hFFFC, NO_WANT}
  };

  // ---------------------------------------------------------------------------
  // predictor state: two rows above, the last two columns in view, position
  // ---------------------------------------------------------------------------
  bsm_pkg::pix_t              two_up  [bsm_pkg::MAX_SIZE];
  bsm_pkg::pix_t              one_up  [bsm_pkg::MAX_SIZE];
  bsm_pkg::pix_t              col_hist [6];  // [2k] previous column, [2k+1] the one before
  int                         next_row;
  int                         next_col;
  logic [bsm_pkg::SIZE_W-1:0] cur_size;

  smoothed_t expected_means [$];          // results still owed by the block
  smoothed_t step_means [$];              // results of the last predicted pixel

  int  mismatches;
  int  cycle_count;
  bit  idle_bursts;                       // random gaps and stalls on both sides
  bit  hold_long_req;                     // asks the receiver for one long hold-off

  // side of the square as the block sees it
  function automatic int side_of(input logic [bsm_pkg::SIZE_W-1:0] sz);
    if (sz == '0) return 1;
    if (sz > bsm_pkg::MAX_SIZE) return bsm_pkg::MAX_SIZE;
    return int'(sz);
  endfunction

  // advance the predictor by one pixel; results land in step_means
  task automatic smooth_step(input bsm_pkg::pix_t px);
    int n, r, c, oi, oj, rlo, rhi, clo, chi, a, b, k, cnt;
    int unsigned sum_r, sum_g, sum_b;
    bsm_pkg::pix_t grid [3][3];
    bsm_pkg::pix_t nb;
    smoothed_t res;
    n = side_of(cur_size);
    r = next_row;
    c = next_col;
    if (r >= n || c >= n) begin
      r = 0;
      c = 0;
    end
    step_means.delete();
    // grid rows are r-2, r-1, r and columns c-2, c-1, c
    for (k = 0; k < 3; k++) begin
      grid[k][0] = col_hist[2*k+1];
      grid[k][1] = col_hist[2*k];
    end
    grid[0][2] = two_up[c];
    grid[1][2] = one_up[c];
    grid[2][2] = px;
    // the pixel up-left is complete now; the one above only at the end of a row,
    // the one to the left only on the last row
    for (oi = r - 1; oi <= r; oi++) begin
      if (oi < 0 || (oi == r && r != n - 1)) continue;
      for (oj = c - 1; oj <= c; oj++) begin
        if (oj < 0 || (oj == c && c != n - 1)) continue;
        rlo = (oi > 0) ? oi - 1 : 0;
        rhi = (oi + 1 > n - 1) ? n - 1 : oi + 1;
        clo = (oj > 0) ? oj - 1 : 0;
        chi = (oj + 1 > n - 1) ? n - 1 : oj + 1;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        cnt = 0;
        for (a = rlo; a <= rhi; a++) begin
          for (b = clo; b <= chi; b++) begin
            nb = grid[a - r + 2][b - c + 2];
            sum_r += nb[bsm_pkg::CH_W-1:0];
            sum_g += nb[2*bsm_pkg::CH_W-1:bsm_pkg::CH_W];
            sum_b += nb[3*bsm_pkg::CH_W-1:2*bsm_pkg::CH_W];
            cnt++;
          end
        end
        res.row       = bsm_pkg::OUT_POS_W'(oi);
        res.col       = bsm_pkg::OUT_POS_W'(oj);
        res.red       = bsm_pkg::CH_W'(sum_r / cnt);
        res.green     = bsm_pkg::CH_W'(sum_g / cnt);
        res.blue      = bsm_pkg::CH_W'(sum_b / cnt);
        res.run_last  = 1'b0;
        res.frame_end = (oi == n - 1 && oj == n - 1);
        step_means.push_back(res);
      end
    end
    if (step_means.size() > 0) begin
      res = step_means.pop_back();
      res.run_last = 1'b1;
      step_means.push_back(res);
    end
    two_up[c] = one_up[c];
    one_up[c] = px;
    for (k = 0; k < 3; k++) begin
      col_hist[2*k+1] = col_hist[2*k];
      col_hist[2*k]   = grid[k][2];
    end
    c++;
    if (c >= n) begin
      c = 0;
      r++;
      if (r >= n) r = 0;
    end
    next_row = r;
    next_col = c;
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [bsm_pkg::CH_W-1:0] got,
                             input logic [bsm_pkg::CH_W-1:0] want, input smoothed_t at);
    if (got !== want)
      report_mismatch($sformatf("%s at (%0d,%0d): got %h, want %h",
                                name, at.row, at.col, got, want));
  endtask

  function automatic logic [bsm_pkg::CH_W-1:0] rand_chan();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return bsm_pkg::CH_W'($urandom);
  endfunction

  // stop offering pixels and let everything owed come out
  task automatic wait_drained();
    pix_if.valid <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // size changes only with the block idle; any write restarts the frame
  task automatic write_size(input logic [bsm_pkg::SIZE_W-1:0] sz);
    wait_drained();
    cfg_if.valid      <= 1'b1;
    cfg_if.image_size <= sz;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    cur_size = sz;
    next_row = 0;
    next_col = 0;
  endtask

  // offer one pixel, maybe after a gap; book its results once accepted
  task automatic send_pixel(input row_kind_t kind, input bsm_pkg::pix_t px,
                            input smoothed_t want);
    int gap;
    if (idle_bursts && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid    <= 1'b1;
    pix_if.red_in   <= px[bsm_pkg::CH_W-1:0];
    pix_if.green_in <= px[2*bsm_pkg::CH_W-1:bsm_pkg::CH_W];
    pix_if.blue_in  <= px[3*bsm_pkg::CH_W-1:2*bsm_pkg::CH_W];
    do @(posedge clk); while (!pix_if.ready);
    smooth_step(px);
    case (kind)
      ROW_PREDICT: foreach (step_means[j]) expected_means.push_back(step_means[j]);
      ROW_TYPED:   expected_means.push_back(want);
      default:     ;  // no result may appear for this pixel
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // clock, timeout
  // ---------------------------------------------------------------------------
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // result side: random stall bursts, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    forever begin
      @(posedge clk);
      if (hold_long_req) begin
        hold_long_req = 1'b0;
        stall = LONG_HOLD;
      end else if (idle_bursts && rst_n && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 9);
      end else begin
        stall = 0;
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
    end
  end

  // compare each accepted result with the oldest one owed
  always @(posedge clk) begin
    smoothed_t got, want;
    if (rst_n && res_if.valid && res_if.ready) begin
      got = '{res_if.out_row, res_if.out_col, res_if.out_red, res_if.out_green,
              res_if.out_blue, res_if.run_last, res_if.frame_end};
      if (expected_means.size() == 0) begin
        report_mismatch($sformatf("result (%0d,%0d) with nothing owed", got.row, got.col));
      end else begin
        want = expected_means.pop_front();
        check_field("row", bsm_pkg::CH_W'(got.row), bsm_pkg::CH_W'(want.row), want);
        check_field("col", bsm_pkg::CH_W'(got.col), bsm_pkg::CH_W'(want.col), want);
        check_field("red", got.red, want.red, want);
        check_field("green", got.green, want.green, want);
        check_field("blue", got.blue, want.blue, want);
        check_field("run_last", bsm_pkg::CH_W'(got.run_last),
                    bsm_pkg::CH_W'(want.run_last), want);
        check_field("frame_end", bsm_pkg::CH_W'(got.frame_end),
                    bsm_pkg::CH_W'(want.frame_end), want);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int i, n, count, sel, rand_sent;
    logic [bsm_pkg::SIZE_W-1:0] sz;
    bit held_once, paused_once, do_hold;
    bsm_pkg::pix_t px;

    // every input known from time zero
    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.image_size = '0;
    pix_if.valid      = 1'b0;
    pix_if.red_in     = '0;
    pix_if.green_in   = '0;
    pix_if.blue_in    = '0;
    res_if.ready      = 1'b0;
    mismatches        = 0;
    cycle_count       = 0;
    idle_bursts       = 1'b1;
    hold_long_req     = 1'b0;
    cur_size          = bsm_pkg::SIZE_W'(bsm_pkg::RESET_SIZE);
    next_row          = 0;
    next_col          = 0;
    held_once         = 1'b0;
    paused_once       = 1'b0;
    rand_sent         = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (i = 0; i < DIR_ROWS; i++) begin
      if (dir_table[i].kind == ROW_SIZE)
        write_size(dir_table[i].size);
      else
        send_pixel(dir_table[i].kind,
                   {dir_table[i].blue, dir_table[i].green, dir_table[i].red},
                   dir_table[i].want);
    end

    // random frames: mostly small whole frames, some cut short so the next
    // size write lands mid-frame, a few single pixels and oversize stubs
    while (rand_sent < RAND_ITEMS) begin
      do_hold = !held_once && rand_sent >= 40;
      sel = $urandom_range(0, 19);
      if (do_hold)       sz = bsm_pkg::SIZE_W'(4);
      else if (sel < 13) sz = bsm_pkg::SIZE_W'($urandom_range(2, 6));
      else if (sel < 15) sz = bsm_pkg::SIZE_W'($urandom_range(7, 9));
      else if (sel < 17) sz = bsm_pkg::SIZE_W'(1);
      else if (sel == 17) sz = '0;
      else               sz = bsm_pkg::SIZE_W'($urandom_range(bsm_pkg::MAX_SIZE, 2047));
      write_size(sz);
      n = side_of(sz);
      if (n >= bsm_pkg::MAX_SIZE) begin
        count = $urandom_range(1, 6);
      end else begin
        count = n * n * $urandom_range(1, 2);
        if (!do_hold && $urandom_range(0, 3) == 0) count = $urandom_range(1, n * n);
      end
      if (do_hold) begin
        // receiver sits still while two whole frames are offered: the block backs up
        count         = 2 * n * n;
        hold_long_req = 1'b1;
        held_once     = 1'b1;
      end
      for (i = 0; i < count && rand_sent < RAND_ITEMS; i++) begin
        if (!paused_once && rand_sent >= 120 && i >= count / 2) begin
          wait_drained();   // sender pause mid-frame until nothing is owed
          paused_once = 1'b1;
        end
        if (rand_sent >= RAND_ITEMS - QUIET_ITEMS) idle_bursts = 1'b0;
        px = {rand_chan(), rand_chan(), rand_chan()};
        send_pixel(ROW_PREDICT, px, NO_WANT);
        rand_sent++;
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
